FILE: src/stwe_pkg.sv
// ----------------------------------------------------------------------------
// stwe_pkg
// Shared types, codes and sizes of the sibling tree walk engine.
// ----------------------------------------------------------------------------
package stwe_pkg;

  localparam int NODE_COUNT  = 15;
  localparam int MAX_RESULTS = 15;
  localparam int WALK_LIMIT  = 4 * NODE_COUNT + 4;

  localparam int IDX_W   = 4;
  localparam int VAL_W   = 8;
  localparam int CMD_W   = 3;
  localparam int DEPTH   = NODE_COUNT + 1;
  localparam int STEP_W  = $clog2(WALK_LIMIT + 1);
  localparam int CHAIN_W = $clog2(NODE_COUNT + 1);
  localparam int CNT_W   = $clog2(MAX_RESULTS + 1);

  localparam logic [IDX_W-1:0] NIL  = '0;
  localparam logic [IDX_W-1:0] ROOT = IDX_W'(1);

  localparam logic [VAL_W-1:0] CHAR_ZERO = VAL_W'(48);

  localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PRE    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POST   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd4;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] child;
    logic [IDX_W-1:0] sib;
    logic [IDX_W-1:0] par;
  } node_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    node_t            wr_data;
  } mem_req_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] node_index;
    logic [VAL_W-1:0] node_value;
    logic [IDX_W-1:0] first_child;
    logic [IDX_W-1:0] next_sibling;
    logic [IDX_W-1:0] parent_index;
    logic [VAL_W-1:0] search_key;
  } in_item_t;

  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] value;
    logic             found;
  } push_t;

  // contents of a node that has never been written
  function automatic node_t reset_node(input logic [IDX_W-1:0] idx);
    node_t n;
    n.value = (idx == NIL) ? '0 : CHAR_ZERO + VAL_W'(idx);
    n.child = NIL;
    n.sib   = NIL;
    n.par   = NIL;
    return n;
  endfunction

endpackage

FILE: src/stwe_mem.sv
// ----------------------------------------------------------------------------
// stwe_mem
// Node table: one write and one registered read per cycle. Per-entry valid
// bits make unwritten entries read as their reset contents.
// ----------------------------------------------------------------------------
module stwe_mem
  import stwe_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mem_req_t req,
  output node_t    rd_data
);

  node_t            mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  node_t            rd_raw_r;
  logic             rd_vld_r;
  logic [IDX_W-1:0] rd_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_raw_r  <= mem[req.rd_addr];
      rd_vld_r  <= vld_r[req.rd_addr];
      rd_addr_r <= req.rd_addr;
    end
  end

  assign rd_data = rd_vld_r ? rd_raw_r : reset_node(rd_addr_r);

endmodule

FILE: src/stwe_out.sv
// ----------------------------------------------------------------------------
// stwe_out
// Result stage: holds one item back so the final one of a command can be
// flagged, caps the count per command and registers the result ports.
// ----------------------------------------------------------------------------
module stwe_out
  import stwe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clear,
  input  push_t            push,
  input  logic             finish,
  output logic             out_strobe,
  output logic [VAL_W-1:0] out_visit_value,
  output logic             out_found,
  output logic             out_last_result
);

  logic             pend_vld_r,  pend_vld_nxt;
  logic [VAL_W-1:0] pend_val_r,  pend_val_nxt;
  logic             pend_fnd_r,  pend_fnd_nxt;
  logic [CNT_W-1:0] cnt_r,       cnt_nxt;
  logic             strobe_r,    strobe_nxt;
  logic [VAL_W-1:0] val_r,       val_nxt;
  logic             fnd_r,       fnd_nxt;
  logic             last_r,      last_nxt;
  logic             take;

  always_comb begin
    take         = push.valid && (cnt_r < CNT_W'(MAX_RESULTS));
    pend_vld_nxt = pend_vld_r;
    pend_val_nxt = pend_val_r;
    pend_fnd_nxt = pend_fnd_r;
    cnt_nxt      = cnt_r;
    strobe_nxt   = 1'b0;
    val_nxt      = pend_val_r;
    fnd_nxt      = pend_fnd_r;
    last_nxt     = finish;
    if (clear) begin
      cnt_nxt = '0;
    end
    if (take) begin
      // older item goes out, new one waits for the next push or finish
      strobe_nxt   = pend_vld_r;
      pend_vld_nxt = 1'b1;
      pend_val_nxt = push.value;
      pend_fnd_nxt = push.found;
      cnt_nxt      = cnt_r + 1'b1;
    end else if (finish) begin
      strobe_nxt   = pend_vld_r;
      pend_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      cnt_r      <= '0;
      strobe_r   <= 1'b0;
    end else begin
      pend_vld_r <= pend_vld_nxt;
      cnt_r      <= cnt_nxt;
      strobe_r   <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_val_r <= pend_val_nxt;
    pend_fnd_r <= pend_fnd_nxt;
    val_r      <= val_nxt;
    fnd_r      <= fnd_nxt;
    last_r     <= last_nxt;
  end

  assign out_strobe      = strobe_r;
  assign out_visit_value = val_r;
  assign out_found       = fnd_r;
  assign out_last_result = last_r;

endmodule

FILE: src/stwe_ctrl.sv
// ----------------------------------------------------------------------------
// stwe_ctrl
// Command sequencer: node writes, the link-following walk (one move per
// cycle against the table's read port) and the unlink of a deleted node.
// ----------------------------------------------------------------------------
module stwe_ctrl
  import stwe_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  in_item_t item,
  input  node_t    rd_data,
  output logic     busy,
  output mem_req_t req,
  output logic     clear,
  output push_t    push,
  output logic     finish
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_WALK     = 7'b0000010,
    S_UL_PAR   = 7'b0000100,
    S_UL_CHAIN = 7'b0001000,
    S_UL_CLEAR = 7'b0010000,
    S_RESULT   = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  state_t             state_r,  state_nxt;
  logic [CMD_W-1:0]   cmd_r,    cmd_nxt;
  logic [VAL_W-1:0]   key_r,    key_nxt;
  logic [IDX_W-1:0]   cursor_r, cursor_nxt;
  logic               ret_r,    ret_nxt;
  logic               visit_r,  visit_nxt;
  logic [STEP_W-1:0]  steps_r,  steps_nxt;
  logic               found_r,  found_nxt;
  logic [IDX_W-1:0]   m_r,      m_nxt;
  logic [IDX_W-1:0]   msib_r,   msib_nxt;
  logic [VAL_W-1:0]   mval_r,   mval_nxt;
  logic [IDX_W-1:0]   k_r,      k_nxt;
  logic [CHAIN_W-1:0] ksteps_r, ksteps_nxt;

  logic [IDX_W-1:0] next_c;
  logic             matched;
  logic             seek;
  logic             listing;

  assign seek    = (cmd_r == CMD_SEARCH) || (cmd_r == CMD_DELETE);
  assign listing = (cmd_r == CMD_PRE) || (cmd_r == CMD_POST);
  assign busy    = (state_r != S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    key_nxt    = key_r;
    cursor_nxt = cursor_r;
    ret_nxt    = ret_r;
    visit_nxt  = visit_r;
    steps_nxt  = steps_r;
    found_nxt  = found_r;
    m_nxt      = m_r;
    msib_nxt   = msib_r;
    mval_nxt   = mval_r;
    k_nxt      = k_r;
    ksteps_nxt = ksteps_r;
    req        = '0;
    push       = '0;
    clear      = 1'b0;
    finish     = 1'b0;
    next_c     = NIL;
    matched    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt = item.command;
          key_nxt = item.search_key;
          if (item.command == CMD_WRITE) begin
            if (item.node_index != NIL) begin
              req.wr_en         = 1'b1;
              req.wr_addr       = item.node_index;
              req.wr_data.value = item.node_value;
              req.wr_data.child = item.first_child;
              req.wr_data.sib   = item.next_sibling;
              req.wr_data.par   = item.parent_index;
            end
          end else if (item.command inside {[CMD_PRE:CMD_DELETE]}) begin
            clear       = 1'b1;
            req.rd_en   = 1'b1;
            req.rd_addr = ROOT;
            cursor_nxt  = ROOT;
            ret_nxt     = 1'b0;
            visit_nxt   = 1'b1;
            steps_nxt   = '0;
            found_nxt   = 1'b0;
            state_nxt   = S_WALK;
          end
        end
      end

      S_WALK: begin
        // preorder reports a node when its entry arrives after a forward move
        if (cmd_r == CMD_PRE && visit_r) begin
          push.valid = 1'b1;
          push.value = rd_data.value;
        end
        if (steps_r == STEP_W'(WALK_LIMIT)) begin
          state_nxt = listing ? S_DONE : S_RESULT;
        end else begin
          steps_nxt = steps_r + 1'b1;
          if (!ret_r && rd_data.child != NIL) begin
            next_c    = rd_data.child;
            ret_nxt   = 1'b0;
            visit_nxt = 1'b1;
          end else begin
            if (seek && rd_data.value == key_r) begin
              matched = 1'b1;
            end else if (cmd_r == CMD_POST) begin
              push.valid = 1'b1;
              push.value = rd_data.value;
            end
            if (rd_data.sib != NIL) begin
              next_c    = rd_data.sib;
              ret_nxt   = 1'b0;
              visit_nxt = 1'b1;
            end else begin
              next_c    = rd_data.par;
              ret_nxt   = 1'b1;
              visit_nxt = 1'b0;
            end
          end
          if (matched) begin
            found_nxt = 1'b1;
            if (cmd_r == CMD_DELETE && cursor_r != ROOT) begin
              m_nxt    = cursor_r;
              msib_nxt = rd_data.sib;
              mval_nxt = rd_data.value;
              if (rd_data.par == NIL) begin
                state_nxt = S_UL_CLEAR;
              end else begin
                req.rd_en   = 1'b1;
                req.rd_addr = rd_data.par;
                cursor_nxt  = rd_data.par;
                state_nxt   = S_UL_PAR;
              end
            end else begin
              state_nxt = S_RESULT;
            end
          end else if (next_c == NIL) begin
            state_nxt = listing ? S_DONE : S_RESULT;
          end else begin
            req.rd_en   = 1'b1;
            req.rd_addr = next_c;
            cursor_nxt  = next_c;
          end
        end
      end

      S_UL_PAR: begin
        // rd_data holds the parent of the match
        if (rd_data.child == m_r) begin
          req.wr_en         = 1'b1;
          req.wr_addr       = cursor_r;
          req.wr_data       = rd_data;
          req.wr_data.child = msib_r;
          state_nxt         = S_UL_CLEAR;
        end else if (rd_data.child == NIL) begin
          state_nxt = S_UL_CLEAR;
        end else begin
          k_nxt       = rd_data.child;
          ksteps_nxt  = '0;
          req.rd_en   = 1'b1;
          req.rd_addr = rd_data.child;
          state_nxt   = S_UL_CHAIN;
        end
      end

      S_UL_CHAIN: begin
        if (rd_data.sib == m_r) begin
          req.wr_en       = 1'b1;
          req.wr_addr     = k_r;
          req.wr_data     = rd_data;
          req.wr_data.sib = msib_r;
          state_nxt       = S_UL_CLEAR;
        end else if (rd_data.sib == NIL ||
                     ksteps_r == CHAIN_W'(NODE_COUNT - 1)) begin
          state_nxt = S_UL_CLEAR;
        end else begin
          k_nxt       = rd_data.sib;
          ksteps_nxt  = ksteps_r + 1'b1;
          req.rd_en   = 1'b1;
          req.rd_addr = rd_data.sib;
        end
      end

      S_UL_CLEAR: begin
        req.wr_en         = 1'b1;
        req.wr_addr       = m_r;
        req.wr_data.value = mval_r;
        req.wr_data.child = NIL;
        req.wr_data.sib   = NIL;
        req.wr_data.par   = NIL;
        state_nxt         = S_RESULT;
      end

      S_RESULT: begin
        push.valid = 1'b1;
        push.found = found_r;
        state_nxt  = S_DONE;
      end

      S_DONE: begin
        finish    = 1'b1;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // parent address for the unlink write is kept in cursor_r
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cursor_r <= ROOT;
      ret_r    <= 1'b0;
      visit_r  <= 1'b0;
      steps_r  <= '0;
      found_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cursor_r <= cursor_nxt;
      ret_r    <= ret_nxt;
      visit_r  <= visit_nxt;
      steps_r  <= steps_nxt;
      found_r  <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    key_r    <= key_nxt;
    m_r      <= m_nxt;
    msib_r   <= msib_nxt;
    mval_r   <= mval_nxt;
    k_r      <= k_nxt;
    ksteps_r <= ksteps_nxt;
  end

endmodule

FILE: src/sibling_tree_walk_engine.sv
// ----------------------------------------------------------------------------
// Operation: a write is done while idle and never raises busy. A walk makes one link move per cycle off
//   the node table's registered read port, at most 64 moves; a delete may add its unlink. Results
//   are held one item back so the final one can be flagged; busy falls as the final result
//   reaches the ports.
// Throughput: one command at a time. Reset: synchronous, active low; node valid
//   bits clear at once, node i reads as '0'+i with nil links. Receiver cannot stall.
// ----------------------------------------------------------------------------
// sibling_tree_walk_engine
// First-child / next-sibling tree table with preorder, postorder, search
// and delete commands.
// ----------------------------------------------------------------------------
module sibling_tree_walk_engine
  import stwe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [CMD_W-1:0] in_command,
  input  logic [IDX_W-1:0] in_node_index,
  input  logic [VAL_W-1:0] in_node_value,
  input  logic [IDX_W-1:0] in_first_child,
  input  logic [IDX_W-1:0] in_next_sibling,
  input  logic [IDX_W-1:0] in_parent_index,
  input  logic [VAL_W-1:0] in_search_key,
  output logic             out_strobe,
  output logic [VAL_W-1:0] out_visit_value,
  output logic             out_found,
  output logic             out_last_result
);

  in_item_t item;
  mem_req_t req;
  node_t    rd_data;
  push_t    push;
  logic     clear;
  logic     finish;
  logic     busy_int;

  assign item.command      = in_command;
  assign item.node_index   = in_node_index;
  assign item.node_value   = in_node_value;
  assign item.first_child  = in_first_child;
  assign item.next_sibling = in_next_sibling;
  assign item.parent_index = in_parent_index;
  assign item.search_key   = in_search_key;

  assign busy = busy_int;

  stwe_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .item    (item),
    .rd_data (rd_data),
    .busy    (busy_int),
    .req     (req),
    .clear   (clear),
    .push    (push),
    .finish  (finish)
  );

  stwe_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (rd_data)
  );

  stwe_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .clear           (clear),
    .push            (push),
    .finish          (finish),
    .out_strobe      (out_strobe),
    .out_visit_value (out_visit_value),
    .out_found       (out_found),
    .out_last_result (out_last_result)
  );

endmodule

FILE: bench/stwe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stwe_checker
// Watches the command and result ports of the tree walk engine, keeps its
// own copy of the node table, predicts the visits of every accepted command
// and compares each strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
module stwe_checker
  import stwe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  logic [CMD_W-1:0] in_command,
  input  logic [IDX_W-1:0] in_node_index,
  input  logic [VAL_W-1:0] in_node_value,
  input  logic [IDX_W-1:0] in_first_child,
  input  logic [IDX_W-1:0] in_next_sibling,
  input  logic [IDX_W-1:0] in_parent_index,
  input  logic [VAL_W-1:0] in_search_key,
  input  logic             out_strobe,
  input  logic [VAL_W-1:0] out_visit_value,
  input  logic             out_found,
  input  logic             out_last_result,
  output int               mismatches,
  output int               outstanding,
  output int               checked
);

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             found;
    logic             last;
  } visit_t;

  logic [VAL_W-1:0] node_val   [DEPTH];
  logic [IDX_W-1:0] node_child [DEPTH];
  logic [IDX_W-1:0] node_sib   [DEPTH];
  logic [IDX_W-1:0] node_par   [DEPTH];

  visit_t command_visits[$];   // visits of the command being predicted
  visit_t expected_visits[$];  // all visits still to come from the engine
  int     mismatch_total = 0;
  int     visits_checked = 0;

  // only the first MAX_RESULTS visits of a command reach the port
  function automatic void log_visit(input logic [VAL_W-1:0] v, input logic f);
    visit_t r;
    if (command_visits.size() < MAX_RESULTS) begin
      r.value = v;
      r.found = f;
      r.last  = 1'b0;
      command_visits.push_back(r);
    end
  endfunction

  function automatic void walk_preorder();
    logic [IDX_W-1:0] cur;
    bit               up;
    int               moves;
    cur   = ROOT;
    up    = 1'b0;
    moves = 0;
    log_visit(node_val[ROOT], 1'b0);
    while (cur != NIL && moves < WALK_LIMIT) begin
      moves++;
      if (!up && node_child[cur] != NIL) begin
        cur = node_child[cur];
        log_visit(node_val[cur], 1'b0);
      end else if (node_sib[cur] != NIL) begin
        cur = node_sib[cur];
        up  = 1'b0;
        log_visit(node_val[cur], 1'b0);
      end else begin
        cur = node_par[cur];
        up  = 1'b1;
      end
    end
  endfunction

  // lists every node in postorder, or returns the first one holding key
  function automatic logic [IDX_W-1:0] walk_postorder(input bit seek,
                                                      input logic [VAL_W-1:0] key);
    logic [IDX_W-1:0] cur;
    bit               up;
    int               moves;
    cur   = ROOT;
    up    = 1'b0;
    moves = 0;
    while (cur != NIL && moves < WALK_LIMIT) begin
      moves++;
      if (!up && node_child[cur] != NIL) begin
        cur = node_child[cur];
      end else begin
        if (seek) begin
          if (node_val[cur] == key) return cur;
        end else begin
          log_visit(node_val[cur], 1'b0);
        end
        if (node_sib[cur] != NIL) begin
          cur = node_sib[cur];
          up  = 1'b0;
        end else begin
          cur = node_par[cur];
          up  = 1'b1;
        end
      end
    end
    return NIL;
  endfunction

  // take the match out of its parent's child list, then drop its own links
  function automatic void unlink_match(input logic [IDX_W-1:0] m);
    logic [IDX_W-1:0] p;
    logic [IDX_W-1:0] k;
    int               hops;
    p    = node_par[m];
    hops = 0;
    if (p != NIL) begin
      if (node_child[p] == m) begin
        node_child[p] = node_sib[m];
      end else begin
        k = node_child[p];
        while (k != NIL && hops < NODE_COUNT) begin
          if (node_sib[k] == m) begin
            node_sib[k] = node_sib[m];
            break;
          end
          k = node_sib[k];
          hops++;
        end
      end
    end
    node_child[m] = NIL;
    node_sib[m]   = NIL;
    node_par[m]   = NIL;
  endfunction

  function automatic void predict_command();
    logic [IDX_W-1:0] hit;
    visit_t           tail;
    command_visits.delete();
    case (in_command)
      CMD_WRITE: begin
        // index 0 is ignored; 4-bit links never exceed the table
        if (in_node_index != NIL) begin
          node_val[in_node_index]   = in_node_value;
          node_child[in_node_index] = in_first_child;
          node_sib[in_node_index]   = in_next_sibling;
          node_par[in_node_index]   = in_parent_index;
        end
      end
      CMD_PRE: walk_preorder();
      CMD_POST: void'(walk_postorder(1'b0, '0));
      CMD_SEARCH: begin
        hit = walk_postorder(1'b1, in_search_key);
        log_visit('0, hit != NIL);
      end
      CMD_DELETE: begin
        hit = walk_postorder(1'b1, in_search_key);
        if (hit != NIL && hit != ROOT) unlink_match(hit);
        log_visit('0, hit != NIL);
      end
      default: ;
    endcase
    if (command_visits.size() > 0) begin
      tail      = command_visits.pop_back();
      tail.last = 1'b1;
      command_visits.push_back(tail);
    end
    foreach (command_visits[i]) expected_visits.push_back(command_visits[i]);
  endfunction

  function automatic void note_mismatch(input string what, input visit_t want,
                                        input visit_t got);
    if (mismatch_total < 10) begin
      $display("%0t: %s: expected value %0d found %0d last %0d, got value %0d found %0d last %0d",
               $realtime, what, want.value, want.found, want.last,
               got.value, got.found, got.last);
    end
    mismatch_total++;
  endfunction

  always @(posedge clk) begin
    visit_t got;
    visit_t want;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        node_val[i]   = (i == 0) ? '0 : CHAR_ZERO + VAL_W'(i);
        node_child[i] = NIL;
        node_sib[i]   = NIL;
        node_par[i]   = NIL;
      end
      expected_visits.delete();
    end else begin
      // results first: a new command's visits always come after older ones
      if (out_strobe) begin
        got.value = out_visit_value;
        got.found = out_found;
        got.last  = out_last_result;
        if (expected_visits.size() == 0) begin
          note_mismatch("result with nothing outstanding", '0, got);
        end else begin
          want = expected_visits.pop_front();
          if (want != got) note_mismatch("result differs", want, got);
        end
        visits_checked++;
      end
      if (start && !busy) predict_command();
    end
    mismatches  <= mismatch_total;
    outstanding <= expected_visits.size();
    checked     <= visits_checked;
  end

endmodule

FILE: bench/sibling_tree_walk_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sibling_tree_walk_engine_test
// Drives the tree walk engine with a short directed sequence (reset tree,
// root delete, ignored writes, spare codes, unlink cases, looping links),
// then with random trees followed by walks, searches, deletes, spare codes and writes, under
// three sender idle rates. Results are checked by stwe_checker.
// ----------------------------------------------------------------------------
module sibling_tree_walk_engine_test;
  import stwe_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int ITEM_GOAL    = 270;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 120;

  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;
  localparam logic [VAL_W-1:0] KEY_BASE        = 8'h41;  // small pool gives repeats

  logic             clk             = 1'b0;
  logic             rst_n           = 1'b0;
  logic             start           = 1'b0;
  logic             busy;
  logic [CMD_W-1:0] in_command      = '0;
  logic [IDX_W-1:0] in_node_index   = '0;
  logic [VAL_W-1:0] in_node_value   = '0;
  logic [IDX_W-1:0] in_first_child  = '0;
  logic [IDX_W-1:0] in_next_sibling = '0;
  logic [IDX_W-1:0] in_parent_index = '0;
  logic [VAL_W-1:0] in_search_key   = '0;
  logic             out_strobe;
  logic [VAL_W-1:0] out_visit_value;
  logic             out_found;
  logic             out_last_result;

  int mismatches;
  int outstanding;
  int checked;

  int idle_pct     = 0;
  int items_sent   = 0;
  int writes_sent  = 0;
  int walks_sent   = 0;
  int lookups_sent = 0;
  int stall_cycles = 0;

  logic [VAL_W-1:0] tree_vals [DEPTH];
  int               tree_size = 1;

  always #(CLK_PERIOD / 2) clk = ~clk;

  sibling_tree_walk_engine i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_node_index   (in_node_index),
    .in_node_value   (in_node_value),
    .in_first_child  (in_first_child),
    .in_next_sibling (in_next_sibling),
    .in_parent_index (in_parent_index),
    .in_search_key   (in_search_key),
    .out_strobe      (out_strobe),
    .out_visit_value (out_visit_value),
    .out_found       (out_found),
    .out_last_result (out_last_result)
  );

  stwe_checker i_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_node_index   (in_node_index),
    .in_node_value   (in_node_value),
    .in_first_child  (in_first_child),
    .in_next_sibling (in_next_sibling),
    .in_parent_index (in_parent_index),
    .in_search_key   (in_search_key),
    .out_strobe      (out_strobe),
    .out_visit_value (out_visit_value),
    .out_found       (out_found),
    .out_last_result (out_last_result),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .checked         (checked)
  );

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("no progress for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // returns at the edge that accepts the item
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                           input logic [VAL_W-1:0] val, input logic [IDX_W-1:0] fc,
                           input logic [IDX_W-1:0] ns, input logic [IDX_W-1:0] par,
                           input logic [VAL_W-1:0] key);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    in_command      <= cmd;
    in_node_index   <= idx;
    in_node_value   <= val;
    in_first_child  <= fc;
    in_next_sibling <= ns;
    in_parent_index <= par;
    in_search_key   <= key;
    // busy only moves at rising edges, so its value at the falling edge holds
    do @(negedge clk); while (busy);
    @(posedge clk);
    items_sent++;
    if (cmd == CMD_WRITE && idx != NIL) begin
      writes_sent++;
    end else if (cmd == CMD_PRE || cmd == CMD_POST) begin
      walks_sent++;
    end else if (cmd == CMD_SEARCH || cmd == CMD_DELETE) begin
      lookups_sent++;
    end
  endtask

  task automatic send_write(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] val,
                            input logic [IDX_W-1:0] fc, input logic [IDX_W-1:0] ns,
                            input logic [IDX_W-1:0] par);
    send_item(CMD_WRITE, idx, val, fc, ns, par, VAL_W'($urandom));
  endtask

  // write fields carry noise; the engine ignores them outside a write
  task automatic send_query(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] key);
    send_item(cmd, IDX_W'($urandom), VAL_W'($urandom), IDX_W'($urandom),
              IDX_W'($urandom), IDX_W'($urandom), key);
  endtask

  task automatic directed_items();
    send_query(CMD_PRE, '0);                   // reset tree: root only
    send_query(CMD_POST, '1);
    send_query(CMD_SEARCH, CHAR_ZERO + 8'd1);  // root value
    send_query(CMD_SEARCH, '0);
    send_query(CMD_DELETE, CHAR_ZERO + 8'd1);  // root match leaves table alone
    send_write(NIL, '1, '1, '1, '1);           // bad index, ignored
    send_query(CMD_SPARE_FIRST, '0);
    send_query(CMD_SPARE_LAST, '1);
    // root(R) -> 2(0), 3(255), 5(B); 3 -> 4(A); node 4 names the wrong parent
    send_write(4'd1, 8'h52, 4'd2, NIL, NIL);
    send_write(4'd2, 8'h00, NIL, 4'd3, 4'd1);
    send_write(4'd3, 8'hff, 4'd4, 4'd5, 4'd1);
    send_write(4'd4, KEY_BASE, NIL, NIL, 4'd2);
    send_write(4'd5, KEY_BASE + 8'd1, NIL, NIL, 4'd1);
    send_query(CMD_PRE, '0);
    send_query(CMD_POST, '0);
    send_query(CMD_SEARCH, 8'hff);
    send_query(CMD_DELETE, KEY_BASE);          // not in its parent's list
    send_query(CMD_POST, '0);                  // walk now ends at nil parent
    send_write(4'd4, KEY_BASE, NIL, NIL, 4'd3);
    send_query(CMD_DELETE, 8'hff);             // middle child, has predecessor
    send_query(CMD_DELETE, 8'h00);             // first child
    send_query(CMD_PRE, '0);
    send_write(4'd5, KEY_BASE + 8'd1, NIL, 4'd5, 4'd1);  // sibling loop
    send_query(CMD_PRE, '0);                   // truncated, hits move limit
    send_query(CMD_SEARCH, 8'h5a);
    send_query(CMD_DELETE, 8'h5a);
  endtask

  // random tree over nodes 1..tree_size, deep chains favored, a few stray links
  task automatic grow_tree();
    logic [IDX_W-1:0] up_of    [DEPTH];
    logic [IDX_W-1:0] first_of [DEPTH];
    logic [IDX_W-1:0] next_of  [DEPTH];
    logic [IDX_W-1:0] tail_of  [DEPTH];
    logic [IDX_W-1:0] c, s, u;
    int               p;
    tree_size = $urandom_range(NODE_COUNT, 1);
    for (int i = 0; i < DEPTH; i++) begin
      up_of[i]    = NIL;
      first_of[i] = NIL;
      next_of[i]  = NIL;
      tail_of[i]  = NIL;
    end
    for (int i = 2; i <= tree_size; i++) begin
      p = ($urandom_range(2) == 0) ? i - 1 : $urandom_range(i - 1, 1);
      up_of[i] = IDX_W'(i - (i - p));
      if (first_of[p] == NIL) first_of[p] = IDX_W'(i);
      else next_of[tail_of[p]] = IDX_W'(i);
      tail_of[p] = IDX_W'(i);
    end
    for (int i = 1; i <= tree_size; i++) begin
      c = first_of[i];
      s = next_of[i];
      u = up_of[i];
      if ($urandom_range(99) < 8) begin
        case ($urandom_range(2))
          0:       c = IDX_W'($urandom);
          1:       s = IDX_W'($urandom);
          default: u = IDX_W'($urandom);
        endcase
      end
      tree_vals[i] = ($urandom_range(1) == 0) ? KEY_BASE + VAL_W'($urandom_range(7))
                                              : VAL_W'($urandom);
      send_write(IDX_W'(i), tree_vals[i], c, s, u);
    end
  endtask

  task automatic random_query();
    logic [VAL_W-1:0] key;
    int               pick;
    pick = $urandom_range(99);
    key  = ($urandom_range(3) != 0) ? tree_vals[$urandom_range(tree_size, 1)]
                                    : VAL_W'($urandom);
    if (pick < 20)      send_query(CMD_PRE, key);
    else if (pick < 40) send_query(CMD_POST, key);
    else if (pick < 65) send_query(CMD_SEARCH, key);
    else if (pick < 90) send_query(CMD_DELETE, key);
    else if (pick < 95) send_query(CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST)), key);
    else send_write(IDX_W'($urandom), VAL_W'($urandom), IDX_W'($urandom),
                    IDX_W'($urandom), IDX_W'($urandom));
  endtask

  initial begin
    int phase_pct [3];
    phase_pct[0] = 33;
    phase_pct[1] = 69;
    phase_pct[2] = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    idle_pct = phase_pct[0];
    directed_items();
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = phase_pct[ph];
      while (items_sent < ITEM_GOAL * (ph + 1) / 3) begin
        grow_tree();
        repeat ($urandom_range(6, 2)) random_query();
      end
    end
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d items: %0d node writes, %0d walks, %0d searches and deletes",
             items_sent, writes_sent, walks_sent, lookups_sent);
    $display("checked %0d results under sender idle rates of 33, 69 and 0 percent",
             checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
